@@ hdl/lgs_pkg.sv @@
// shared constants, codes and item types for the life generation step block
// no dependencies; imported by every module of the block
package lgs_pkg;

    localparam int GRID_COLS = 128;
    localparam int GRID_ROWS = 128;
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);

    localparam int CMD_W   = 2;
    localparam int COORD_W = 7;
    localparam int GEN_W   = 32;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    typedef logic [GRID_COLS-1:0] t_row;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               cell_in;
    } t_in_item;

    typedef struct packed {
        logic             cell_out;
        logic [GEN_W-1:0] generation;
        logic             coord_error;
    } t_out_item;

    // one access to the row memory
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        t_row             wr_data;
        logic             clr;
    } t_mem_req;

endpackage

@@ hdl/lgs_row_mem.sv @@
// grid store: one memory row per grid row, one read and one write port
// a valid bit per row makes reset and clear take effect at once; uses lgs_pkg
module lgs_row_mem
    import lgs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_row     o_rd_data
);

    t_row                 r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_valid;
    t_row                 r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // a row never written since reset or clear reads as all dead
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ hdl/lgs_next_row.sv @@
// b3/s23 rule applied to a whole row at once from the old rows around it
// cells beyond the left and right edge count as dead; uses lgs_pkg
module lgs_next_row
    import lgs_pkg::*;
(
    input  t_row i_above,
    input  t_row i_cur,
    input  t_row i_below,
    output t_row o_next
);

    localparam logic [3:0] BIRTH_CNT   = 4'd3;
    localparam logic [3:0] SURVIVE_CNT = 4'd2;

    logic [GRID_COLS+1:0] a_ext;
    logic [GRID_COLS+1:0] c_ext;
    logic [GRID_COLS+1:0] b_ext;
    logic [3:0]           cnt;

    always_comb begin
        a_ext = {1'b0, i_above, 1'b0};
        c_ext = {1'b0, i_cur, 1'b0};
        b_ext = {1'b0, i_below, 1'b0};
        cnt   = '0;
        o_next = '0;
        // lane x sits at x+1 in the padded vectors
        for (int x = 0; x < GRID_COLS; x++) begin
            cnt = {3'b0, a_ext[x]} + {3'b0, a_ext[x+1]} + {3'b0, a_ext[x+2]}
                + {3'b0, c_ext[x]}                      + {3'b0, c_ext[x+2]}
                + {3'b0, b_ext[x]} + {3'b0, b_ext[x+1]} + {3'b0, b_ext[x+2]};
            o_next[x] = (cnt == BIRTH_CNT) || (i_cur[x] && cnt == SURVIVE_CNT);
        end
    end

endmodule

@@ hdl/life_automaton_generation_step_top.sv @@
// top level of the life generation step block: command sequencer and output register
// depends on lgs_pkg, lgs_row_mem and lgs_next_row
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | from block| o_out_valid/ i_out_stall| o_out_item (t_out_item)
//
// write and read: row read, modify or pick, result; clear and a bad coordinate go
// straight to the result. advance: one grid row per cycle
// through the row memory, whose single read port sets the pace.
// reset clears the per-row valid bits at once, so no clearing pass is needed.
// one finished item may wait in the output register while the next one runs;
// the input is stalled whenever the sequencer is busy.
module life_automaton_generation_step_top
    import lgs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RMW  = 3'd1;
    localparam logic [2:0] S_PRE  = 3'd2;
    localparam logic [2:0] S_ROW  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state,     n_state;
    logic [ROW_W-1:0] r_y,         n_y;
    t_row             r_above,     n_above;
    t_row             r_cur,       n_cur;
    t_in_item         r_item,      n_item;
    logic [GEN_W-1:0] r_gen,       n_gen;
    t_out_item        r_res,       n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_item,  n_out_item;

    t_mem_req         mem_req;
    t_row             rd_data;
    t_row             below;
    t_row             next_row;
    t_row             mod_row;
    logic             last_row;
    logic [ROW_W:0]   y_ahead;
    logic             bad_coord;
    logic [COL_W-1:0] col_idx;
    logic [ROW_W-1:0] row_idx;
    logic             out_free;

    lgs_row_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    lgs_next_row u_rule (
        .i_above (r_above),
        .i_cur   (r_cur),
        .i_below (below),
        .o_next  (next_row)
    );

    assign last_row = (r_y == ROW_W'(GRID_ROWS - 1));
    assign below    = last_row ? '0 : rd_data;
    assign y_ahead  = {1'b0, r_y} + (ROW_W+1)'(2);
    assign out_free = !r_out_valid || !i_out_stall;

    assign bad_coord = (32'(i_in_item.col) >= GRID_COLS) || (32'(i_in_item.row) >= GRID_ROWS);
    assign col_idx   = COL_W'(r_item.col);
    assign row_idx   = ROW_W'(r_item.row);

    always_comb begin
        mod_row          = rd_data;
        mod_row[col_idx] = r_item.cell_in;
    end

    always_comb begin
        n_state     = r_state;
        n_y         = r_y;
        n_above     = r_above;
        n_cur       = r_cur;
        n_item      = r_item;
        n_gen       = r_gen;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        mem_req     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    unique case (i_in_item.cmd)
                        CMD_WRITE, CMD_READ: begin
                            if (bad_coord) begin
                                n_res   = '{cell_out: 1'b0, generation: r_gen, coord_error: 1'b1};
                                n_state = S_DONE;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = ROW_W'(i_in_item.row);
                                n_state         = S_RMW;
                            end
                        end
                        CMD_STEP: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            n_state         = S_PRE;
                        end
                        CMD_CLEAR: begin
                            mem_req.clr = 1'b1;
                            n_res       = '{cell_out: 1'b0, generation: r_gen, coord_error: 1'b0};
                            n_state     = S_DONE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RMW: begin
                if (r_item.cmd == CMD_WRITE) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = row_idx;
                    mem_req.wr_data = mod_row;
                    n_res = '{cell_out: 1'b0, generation: r_gen, coord_error: 1'b0};
                end else begin
                    n_res = '{cell_out: rd_data[col_idx], generation: r_gen, coord_error: 1'b0};
                end
                n_state = S_DONE;
            end
            S_PRE: begin
                // row 0 has arrived; fetch row 1 so it is ready as the row below
                n_cur           = rd_data;
                n_above         = '0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ROW_W'(1);
                n_y             = '0;
                n_state         = S_ROW;
            end
            S_ROW: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_y;
                mem_req.wr_data = next_row;
                n_above         = r_cur;
                n_cur           = below;
                // rows ahead are still old, so reading two ahead never sees new data
                if (y_ahead < (ROW_W+1)'(GRID_ROWS)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = y_ahead[ROW_W-1:0];
                end
                if (last_row) begin
                    n_gen   = r_gen + GEN_W'(1);
                    n_res   = '{cell_out: 1'b0, generation: r_gen + GEN_W'(1), coord_error: 1'b0};
                    n_state = S_DONE;
                end else begin
                    n_y = r_y + ROW_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y        <= n_y;
        r_above    <= n_above;
        r_cur      <= n_cur;
        r_item     <= n_item;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
